// ----- hw/rtl/pdq_pkg.sv -----
package pdq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam int CFG_W = 9;
   localparam int COUNT_W = 6;

   localparam logic [CFG_W-1:0] REPLY_NONE = 9'd256;
   localparam logic [7:0] BYTE_NO_PRESS = 8'd254;
   localparam logic [7:0] BYTE_PAD_OFF = 8'd252;
   localparam logic [7:0] BYTE_BUTTON_LO = 8'd128;
   localparam logic [7:0] BYTE_ENCODER_LO = 8'd180;

   typedef enum logic [1:0] {
      OP_SERIAL,
      OP_POP,
      OP_MIDI_IN,
      OP_MIDI_OUT
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_PAD_PRESS,
      KIND_PAD_RELEASE,
      KIND_BUTTON_PRESS,
      KIND_BUTTON_RELEASE,
      KIND_ENCODER,
      KIND_MIDI_IN,
      KIND_MIDI_OUT
   } kind_type;

   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_QUEUED,
      PUSH_DROPPED
   } push_status_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PAD_OFF,
      PH_PAD_ON,
      PH_ENCODER
   } phase_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_PUSH,
      CMD_POP
   } cmd_op_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  id;
      logic [15:0] value;
      logic [15:0] time_stamp;
   } event_type;

   localparam int EVENT_W = $bits(event_type);

   typedef struct packed {
      cmd_op_type op;
      logic       reply_seen;
      event_type  ev;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  byte_in;
      logic [7:0]  midi_first;
      logic [7:0]  midi_second;
      logic [15:0] time_now;
   } req_type;

   typedef struct packed {
      logic               event_valid;
      logic [2:0]         event_kind;
      logic [7:0]         event_id;
      logic [15:0]        event_value;
      logic [15:0]        event_time;
      logic [1:0]         push_status;
      logic               display_reply_seen;
      logic [COUNT_W-1:0] queue_count;
   } rsp_type;

endpackage

// ----- hw/rtl/panel_event_decoder_queue.sv -----
// A request is queued, then its result registered. Throughput: one request word per
// cycle while results are not stalled; the decoder, the two-entry command queue and
// the event store's single write and registered read port each take one per cycle.
// Reset is synchronous and active high; it empties the event queue, returns the
// parser to idle and sets the awaited display reply to none. No clearing pass runs.
module panel_event_decoder_queue
   import pdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0] reply_ff;
   logic             front_valid, front_ready;
   cmd_type          front_cmd;
   logic             back_valid, back_ready;
   cmd_type          back_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_ff <= REPLY_NONE;
      end else if (csr_valid && csr_ready) begin
         reply_ff <= csr_data;
      end
   end

   pdq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .reply_byte (reply_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   pdq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   pdq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- hw/rtl/pdq_ram.sv -----
module pdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/pdq_front.sv -----
module pdq_front
   import pdq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [CFG_W-1:0] reply_byte,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_word,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output cmd_type          cmd
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] ptime_ff, ptime_in;
   logic        accept;
   logic [7:0]  b;
   logic [15:0] delta;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept = req_valid && cmd_ready;
   assign b = req_word.byte_in;
   assign delta = {{8{b[7]}}, b};

   always_comb begin
      phase_in = phase_ff;
      code_in = code_ff;
      ptime_in = ptime_ff;
      cmd = '0;
      cmd.op = CMD_NONE;
      unique case (opcode_type'(req_word.opcode))
         OP_SERIAL: begin
            priority if (phase_ff == PH_PAD_OFF) begin
               cmd.op = CMD_PUSH;
               cmd.ev = '{KIND_PAD_RELEASE, b, 16'd0, ptime_ff};
               phase_in = PH_IDLE;
            end else if (phase_ff == PH_PAD_ON) begin
               cmd.op = CMD_PUSH;
               cmd.ev = '{KIND_PAD_PRESS, code_ff, {8'd0, b}, ptime_ff};
               phase_in = PH_IDLE;
            end else if (phase_ff == PH_ENCODER) begin
               cmd.op = CMD_PUSH;
               cmd.ev = '{KIND_ENCODER, code_ff - BYTE_ENCODER_LO, delta, ptime_ff};
               phase_in = PH_IDLE;
            end else if (reply_byte != REPLY_NONE && b == reply_byte[7:0]) begin
               cmd.reply_seen = 1'b1;
            end else if (b == BYTE_NO_PRESS) begin
               cmd.op = CMD_NONE;
            end else if (b == BYTE_PAD_OFF) begin
               ptime_in = req_word.time_now;
               phase_in = PH_PAD_OFF;
            end else if (b < BYTE_BUTTON_LO) begin
               code_in = b;
               ptime_in = req_word.time_now;
               phase_in = PH_PAD_ON;
            end else if (b < BYTE_ENCODER_LO) begin
               cmd.op = CMD_PUSH;
               cmd.ev = '{KIND_BUTTON_RELEASE, {1'b0, b[6:0]}, 16'd0, req_word.time_now};
            end else begin
               code_in = b;
               ptime_in = req_word.time_now;
               phase_in = PH_ENCODER;
            end
         end
         OP_POP: begin
            cmd.op = CMD_POP;
         end
         OP_MIDI_IN, OP_MIDI_OUT: begin
            cmd.op = CMD_PUSH;
            cmd.ev.kind = (opcode_type'(req_word.opcode) == OP_MIDI_IN) ?
                          KIND_MIDI_IN : KIND_MIDI_OUT;
            cmd.ev.id = b;
            cmd.ev.value = {req_word.midi_first, req_word.midi_second};
            cmd.ev.time_stamp = req_word.time_now;
         end
         default: begin
            cmd.op = CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         code_ff <= '0;
         ptime_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         code_ff <= code_in;
         ptime_ff <= ptime_in;
      end
   end

endmodule

// ----- hw/rtl/pdq_cmd_fifo.sv -----
module pdq_cmd_fifo
   import pdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type                entries_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]  count_ff, count_in;
   logic                   do_wr, do_rd;

   assign in_ready = count_ff != CMDQ_CNT_W'(CMDQ_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd = entries_ff[rd_ptr_ff];
   assign do_wr = in_valid && in_ready;
   assign do_rd = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- hw/rtl/pdq_back.sv -----
module pdq_back
   import pdq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   logic [QIDX_W-1:0]  wr_ff, wr_in, next_wr;
   logic [QIDX_W-1:0]  rd_ff, rd_in, next_rd;
   logic [QIDX_W-1:0]  held;
   logic               issue, full, empty, do_push, do_pop;
   logic               out_valid_ff, out_valid_in;
   logic               hit_ff;
   logic               seen_ff;
   push_status_type    status_ff, status_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [EVENT_W-1:0] rd_bits;
   event_type          rd_ev;

   assign cmd_ready = !out_valid_ff || rsp_ready;
   assign issue = cmd_valid && cmd_ready;

   assign next_wr = (wr_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign next_rd = (rd_ff == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign full = next_wr == rd_ff;
   assign empty = wr_ff == rd_ff;
   assign do_push = issue && cmd.op == CMD_PUSH && !full;
   assign do_pop = issue && cmd.op == CMD_POP && !empty;
   assign wr_in = do_push ? next_wr : wr_ff;
   assign rd_in = do_pop ? next_rd : rd_ff;

   always_comb begin
      if (wr_in >= rd_in) begin
         held = wr_in - rd_in;
      end else begin
         held = QIDX_W'(QUEUE_DEPTH) - rd_in + wr_in;
      end
      count_in = COUNT_W'(32'(held));
      if (cmd.op == CMD_PUSH) begin
         status_in = full ? PUSH_DROPPED : PUSH_QUEUED;
      end else begin
         status_in = PUSH_NONE;
      end
      out_valid_in = issue ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   pdq_ram #(
      .WIDTH (EVENT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ff),
      .wr_data (cmd.ev),
      .rd_en   (do_pop),
      .rd_addr (rd_ff),
      .rd_data (rd_bits)
   );

   assign rd_ev = event_type'(rd_bits);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         hit_ff <= do_pop;
         seen_ff <= cmd.reply_seen;
         status_ff <= status_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      rsp_word = '0;
      rsp_word.event_valid = hit_ff;
      if (hit_ff) begin
         rsp_word.event_kind = rd_ev.kind;
         rsp_word.event_id = rd_ev.id;
         rsp_word.event_value = rd_ev.value;
         rsp_word.event_time = rd_ev.time_stamp;
      end
      rsp_word.push_status = status_ff;
      rsp_word.display_reply_seen = seen_ff;
      rsp_word.queue_count = count_ff;
   end

   assign rsp_valid = out_valid_ff;

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      issue && cmd.op == CMD_POP && empty |=> rsp_valid && !rsp_word.event_valid)
      else $error("Pop of an empty queue returned an event.");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      issue && cmd.op == CMD_PUSH && full |=>
      rsp_valid && rsp_word.push_status == PUSH_DROPPED && $stable(wr_ff))
      else $error("Push to a full queue was not dropped.");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(wr_ff) && $stable(rd_ff))
      else $error("Queue indices moved while the result word was stalled.");

endmodule

// ----- dv/tb_panel_event_decoder_queue.sv -----
module tb_panel_event_decoder_queue;
   import pdq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             is_cfg;
      logic [CFG_W-1:0] cfg;
      req_type          req;
      logic             typed;
      rsp_type          rsp;
   } step_row;

   localparam rsp_type RSP_QUIET = '0;
   localparam int SND_IDLE_PCT [3] = '{18, 62, 0};
   localparam int RCV_IDLE_PCT [3] = '{62, 18, 0};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_word = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_word;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   logic    word_typed = 1'b0;
   rsp_type word_typed_rsp = '0;

   int snd_idle_pct = 0;
   int rcv_idle_pct = 0;
   int mismatches = 0;

   rsp_type expected_rsps [$];
   step_row directed_steps [$];

   logic [CFG_W-1:0] reply_cfg = REPLY_NONE;
   phase_type        parse_phase = PH_IDLE;
   logic [7:0]       pend_code = '0;
   logic [15:0]      pend_time = '0;
   event_type        event_store [QUEUE_DEPTH];
   int               wr_idx = 0;
   int               rd_idx = 0;

   panel_event_decoder_queue u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= 100) begin
         $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      end
   endtask

   function automatic push_status_type store_event(input kind_type kind, input logic [7:0] id,
                                                   input logic [15:0] value,
                                                   input logic [15:0] stamp);
      int nxt;
      nxt = (wr_idx + 1) % QUEUE_DEPTH;
      if (nxt == rd_idx) begin
         return PUSH_DROPPED;
      end
      event_store[wr_idx].kind = kind;
      event_store[wr_idx].id = id;
      event_store[wr_idx].value = value;
      event_store[wr_idx].time_stamp = stamp;
      wr_idx = nxt;
      return PUSH_QUEUED;
   endfunction

   function automatic rsp_type decode_step(input req_type w);
      rsp_type    o;
      event_type  ev;
      kind_type   midi_kind;
      logic [7:0] b;
      o = '0;
      b = w.byte_in;
      case (w.opcode)
         OP_SERIAL: begin
            case (parse_phase)
               PH_PAD_OFF: begin
                  o.push_status = store_event(KIND_PAD_RELEASE, b, 16'h0000, pend_time);
                  parse_phase = PH_IDLE;
               end
               PH_PAD_ON: begin
                  o.push_status = store_event(KIND_PAD_PRESS, pend_code, {8'h00, b}, pend_time);
                  parse_phase = PH_IDLE;
               end
               PH_ENCODER: begin
                  o.push_status = store_event(KIND_ENCODER, pend_code - BYTE_ENCODER_LO,
                                              {{8{b[7]}}, b}, pend_time);
                  parse_phase = PH_IDLE;
               end
               default: begin
                  if (reply_cfg != REPLY_NONE && b == reply_cfg[7:0]) begin
                     o.display_reply_seen = 1'b1;
                  end else if (b == BYTE_PAD_OFF) begin
                     pend_time = w.time_now;
                     parse_phase = PH_PAD_OFF;
                  end else if (b < BYTE_BUTTON_LO) begin
                     pend_code = b;
                     pend_time = w.time_now;
                     parse_phase = PH_PAD_ON;
                  end else if (b < BYTE_ENCODER_LO) begin
                     o.push_status = store_event(KIND_BUTTON_RELEASE, {1'b0, b[6:0]}, 16'h0000,
                                                 w.time_now);
                  end else if (b != BYTE_NO_PRESS) begin
                     pend_code = b;
                     pend_time = w.time_now;
                     parse_phase = PH_ENCODER;
                  end
               end
            endcase
         end
         OP_POP: begin
            if (wr_idx != rd_idx) begin
               ev = event_store[rd_idx];
               o.event_valid = 1'b1;
               o.event_kind = ev.kind;
               o.event_id = ev.id;
               o.event_value = ev.value;
               o.event_time = ev.time_stamp;
               rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
            end
         end
         default: begin
            if (w.opcode == OP_MIDI_IN) begin
               midi_kind = KIND_MIDI_IN;
            end else begin
               midi_kind = KIND_MIDI_OUT;
            end
            o.push_status = store_event(midi_kind, b, {w.midi_first, w.midi_second},
                                        w.time_now);
         end
      endcase
      o.queue_count = COUNT_W'((wr_idx - rd_idx + QUEUE_DEPTH) % QUEUE_DEPTH);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         reply_cfg = REPLY_NONE;
         parse_phase = PH_IDLE;
         pend_code = '0;
         pend_time = '0;
         wr_idx = 0;
         rd_idx = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("result word with none expected", 64'(rsp_word), 64'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_word.event_valid !== want.event_valid)
                  report_mismatch("event_valid", 64'(rsp_word.event_valid),
                                  64'(want.event_valid));
               if (rsp_word.event_kind !== want.event_kind)
                  report_mismatch("event_kind", 64'(rsp_word.event_kind),
                                  64'(want.event_kind));
               if (rsp_word.event_id !== want.event_id)
                  report_mismatch("event_id", 64'(rsp_word.event_id), 64'(want.event_id));
               if (rsp_word.event_value !== want.event_value)
                  report_mismatch("event_value", 64'(rsp_word.event_value),
                                  64'(want.event_value));
               if (rsp_word.event_time !== want.event_time)
                  report_mismatch("event_time", 64'(rsp_word.event_time),
                                  64'(want.event_time));
               if (rsp_word.push_status !== want.push_status)
                  report_mismatch("push_status", 64'(rsp_word.push_status),
                                  64'(want.push_status));
               if (rsp_word.display_reply_seen !== want.display_reply_seen)
                  report_mismatch("display_reply_seen", 64'(rsp_word.display_reply_seen),
                                  64'(want.display_reply_seen));
               if (rsp_word.queue_count !== want.queue_count)
                  report_mismatch("queue_count", 64'(rsp_word.queue_count),
                                  64'(want.queue_count));
            end
         end
         if (csr_valid && csr_ready) begin
            reply_cfg = csr_data;
         end
         if (req_valid && req_ready) begin
            want = decode_step(req_word);
            expected_rsps.push_back(word_typed ? word_typed_rsp : want);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
   end

   function automatic req_type rand_word(input opcode_type op, input logic [7:0] b);
      req_type w;
      w.opcode = op;
      w.byte_in = b;
      w.midi_first = 8'($urandom_range(0, 255));
      w.midi_second = 8'($urandom_range(0, 255));
      w.time_now = 16'($urandom_range(0, 65535));
      return w;
   endfunction

   function automatic step_row req_row(input opcode_type op, input logic [7:0] b,
                                       input logic [7:0] d1, input logic [7:0] d2,
                                       input logic [15:0] t, input logic typed);
      step_row r;
      r = '0;
      r.req.opcode = op;
      r.req.byte_in = b;
      r.req.midi_first = d1;
      r.req.midi_second = d2;
      r.req.time_now = t;
      r.typed = typed;
      r.rsp = RSP_QUIET;
      return r;
   endfunction

   function automatic step_row cfg_row(input logic [CFG_W-1:0] value);
      step_row r;
      r = '0;
      r.is_cfg = 1'b1;
      r.cfg = value;
      return r;
   endfunction

   task automatic send_word(input req_type w, input logic typed, input rsp_type typed_rsp);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      word_typed <= typed;
      word_typed_rsp <= typed_rsp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic write_reply_cfg(input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int items, input int pop_pct);
      int         sent;
      logic       is_pair;
      opcode_type op;
      logic [7:0] first;
      sent = 0;
      while (sent < items) begin
         is_pair = 1'b0;
         op = OP_SERIAL;
         first = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 9))
            0: op = OP_MIDI_IN;
            1: op = OP_MIDI_OUT;
            2, 3: begin
               first = 8'($urandom_range(0, 127));
               is_pair = 1'b1;
            end
            4: begin
               first = BYTE_PAD_OFF;
               is_pair = 1'b1;
            end
            5, 6: begin
               first = 8'($urandom_range(180, 255));
               is_pair = 1'b1;
            end
            7: first = 8'($urandom_range(128, 179));
            8: first = reply_cfg[7:0];
            default: first = 8'($urandom_range(0, 255));
         endcase
         if ($urandom_range(0, 99) < pop_pct) begin
            op = OP_POP;
            is_pair = 1'b0;
         end
         send_word(rand_word(op, first), 1'b0, RSP_QUIET);
         sent++;
         if (is_pair) begin
            if ($urandom_range(0, 4) == 0) begin
               send_word(rand_word(opcode_type'($urandom_range(1, 3)),
                                   8'($urandom_range(0, 255))),
                         1'b0, RSP_QUIET);
               sent++;
            end
            send_word(rand_word(OP_SERIAL, 8'($urandom_range(0, 255))), 1'b0, RSP_QUIET);
            sent++;
         end
      end
   endtask

   initial begin
      logic [CFG_W-1:0] cfg_value;

      directed_steps.push_back(req_row(OP_POP,      8'h00, 8'h00, 8'h00, 16'h0000, 1'b1));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hFE, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b1));
      directed_steps.push_back(req_row(OP_POP,      8'hFF, 8'hFF, 8'hFF, 16'h0000, 1'b1));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hFF, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h7F, 8'h00, 8'h00, 16'h1234, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hFC, 8'h00, 8'h00, 16'hFFFF, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hFE, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h80, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hB3, 8'h00, 8'h00, 16'h5A5A, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hB4, 8'h00, 8'h00, 16'hABCD, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h80, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hFF, 8'h00, 8'h00, 16'h0001, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h7F, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_MIDI_IN,  8'hFF, 8'hFF, 8'h00, 16'hFFFF, 1'b0));
      directed_steps.push_back(req_row(OP_MIDI_OUT, 8'h00, 8'h00, 8'hFF, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_POP,      8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_POP,      8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_POP,      8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(cfg_row(9'h1FC));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hFC, 8'h00, 8'h00, 16'h7777, 1'b0));
      directed_steps.push_back(cfg_row(9'h000));
      directed_steps.push_back(req_row(OP_SERIAL,   8'hB4, 8'h00, 8'h00, 16'h0100, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h00, 8'h00, 8'h00, 16'h0000, 1'b0));
      directed_steps.push_back(req_row(OP_SERIAL,   8'h00, 8'h00, 8'h00, 16'hFFFF, 1'b0));

      snd_idle_pct = SND_IDLE_PCT[0];
      rcv_idle_pct = RCV_IDLE_PCT[0];
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_cfg) begin
            write_reply_cfg(directed_steps[i].cfg);
         end else begin
            send_word(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].rsp);
         end
      end

      // Even phases fill the queue toward full, odd phases drain it past empty.
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: cfg_value = REPLY_NONE;
            1: cfg_value = 9'd255;
            2: cfg_value = 9'd511;
            3: cfg_value = 9'($urandom_range(0, 255));
            4: cfg_value = 9'($urandom_range(257, 510));
            default: cfg_value = 9'd128;
         endcase
         write_reply_cfg(cfg_value);
         snd_idle_pct = SND_IDLE_PCT[p / 2];
         rcv_idle_pct = RCV_IDLE_PCT[p / 2];
         run_random(280, (p % 2 == 0) ? 10 : 50);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/pdq_pkg.sv
hw/rtl/pdq_ram.sv
hw/rtl/pdq_front.sv
hw/rtl/pdq_cmd_fifo.sv
hw/rtl/pdq_back.sv
hw/rtl/panel_event_decoder_queue.sv
dv/tb_panel_event_decoder_queue.sv
